FILE: src/sspq_pkg.sv
// Package: shared types and codes for the sorted priority queue.
`timescale 1ns / 1ps

package sspq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int CODE_W    = 16;
	localparam int PRIO_W    = 8;
	localparam int STATUS_W  = 2;
	localparam int FILL_W    = 5;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic              cmd;
		logic [CODE_W-1:0] entry_code;
		logic [PRIO_W-1:0] entry_priority;
	} req_t;

	typedef struct packed {
		logic                out_valid;
		logic [CODE_W-1:0]   out_code;
		logic [PRIO_W-1:0]   out_priority;
		logic [STATUS_W-1:0] status;
		logic [FILL_W-1:0]   fill_count;
	} rsp_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// Broadcast control from the top level to every cell.
	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t new_ent;
	} cell_ctrl_t;

endpackage

FILE: src/sspq_cell.sv
// One cell of the queue: holds one entry and shifts toward either neighbor.
`timescale 1ns / 1ps

module sspq_cell (
	input  logic                clk,
	input  sspq_pkg::cell_ctrl_t ctrl,
	input  logic                occ,
	input  logic                left_gt,
	input  sspq_pkg::entry_t    left_ent,
	input  sspq_pkg::entry_t    right_ent,
	output sspq_pkg::entry_t    ent,
	output logic                gt
);
	import sspq_pkg::*;

	entry_t ent_q;

	// This cell holds an entry that must move behind the new one.
	assign gt  = occ && (ent_q.prio > ctrl.new_ent.prio);
	assign ent = ent_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && (gt || !occ)) begin
			ent_q <= left_gt ? left_ent : ctrl.new_ent;
		end else if (ctrl.rem) begin
			ent_q <= right_ent;
		end
	end

endmodule

FILE: src/stable_sorted_priority_queue_top.sv
// Top level: sorted priority queue built from a chain of shifting cells.
`timescale 1ns / 1ps

// Usage
// The request channel (req_valid, req_stall, req) carries one command per item:
// an insert of a code and priority, or a remove of the front entry. The
// response channel (rsp_valid, rsp_stall, rsp) returns exactly one item per
// command, holding the removed entry if any, a status code and the fill count.
// Each cell compares its stored priority with the incoming one in parallel,
// so the response is registered and appears in the cycle after the request
// is accepted, and one command per cycle is taken as long as the receiver
// keeps rsp_stall low. The single response register sets this rate.
// Equal priorities leave in arrival order. An insert into a full queue and a
// remove from an empty queue leave the store unchanged and are flagged in
// the status field.
// Reset clears the fill count and the response valid; stored entries are not
// cleared, since only slots below the fill count are ever read.
// While the receiver stalls a pending response, req_stall is raised and the
// response is held unchanged until it is taken.

module stable_sorted_priority_queue_top #(
	parameter int DEPTH = sspq_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sspq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sspq_pkg::rsp_t rsp
);
	import sspq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             accept;
	logic             full;
	logic             empty;
	logic             do_ins;
	logic             do_rem;
	cell_ctrl_t       ctrl;
	entry_t           cell_ent [DEPTH];
	logic [DEPTH-1:0] cell_gt;
	logic [DEPTH-1:0] occ;
	logic [CNT_W-1:0] count_nxt;

	// A new command may enter whenever the response register is empty or
	// is being emptied in this cycle.
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign do_ins = accept && (req.cmd == CMD_INSERT) && !full;
	assign do_rem = accept && (req.cmd == CMD_REMOVE) && !empty;

	assign ctrl.ins             = do_ins;
	assign ctrl.rem             = do_rem;
	assign ctrl.new_ent.code    = req.entry_code;
	assign ctrl.new_ent.prio    = req.entry_priority;

	// Each cell gets its neighbors' contents: the left one for an insert
	// shift toward the back, the right one for a remove shift to the front.
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			entry_t left_ent;
			entry_t right_ent;
			logic   left_gt;

			assign occ[gi] = (CNT_W'(gi) < count_q);

			if (gi == 0) begin : g_first
				assign left_ent = ctrl.new_ent;
				assign left_gt  = 1'b0;
			end else begin : g_mid
				assign left_ent = cell_ent[gi-1];
				assign left_gt  = cell_gt[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_last
				assign right_ent = cell_ent[gi];
			end else begin : g_inner
				assign right_ent = cell_ent[gi+1];
			end

			sspq_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.occ       (occ[gi]),
				.left_gt   (left_gt),
				.left_ent  (left_ent),
				.right_ent (right_ent),
				.ent       (cell_ent[gi]),
				.gt        (cell_gt[gi])
			);
		end
	endgenerate

	always_comb begin
		count_nxt = count_q;
		if (do_ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (do_rem) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// The response payload is loaded only when a command is accepted.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.out_valid    <= do_rem;
			rsp_q.out_code     <= do_rem ? cell_ent[0].code : '0;
			rsp_q.out_priority <= do_rem ? cell_ent[0].prio : '0;
			if (req.cmd == CMD_INSERT && full) begin
				rsp_q.status <= ST_FULL;
			end else if (req.cmd == CMD_REMOVE && empty) begin
				rsp_q.status <= ST_EMPTY;
			end else begin
				rsp_q.status <= ST_OK;
			end
			rsp_q.fill_count <= FILL_W'(count_nxt);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The fill count never passes the number of cells.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	// An accepted insert into a queue with room grows the count by one.
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.cmd == CMD_INSERT && !full) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the queue");

	// A remove from an empty queue answers with the empty status and no entry.
	a_rem_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.cmd == CMD_REMOVE && empty) |=>
		(rsp_valid && rsp.status == ST_EMPTY && !rsp.out_valid))
		else $error("remove on empty not flagged");

	// A command that is taken always leaves a response pending.
	a_rsp_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid)
		else $error("accepted command produced no response");

endmodule
